>>> rtl/core/prsm_pkg.sv
package prsm_pkg;

    // Default sizes
    localparam int SRC_DEPTH_DEF = 256;
    localparam int OUT_MAX_DEF   = 64;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int ACC_W  = 25;   // phase accumulator and step
    localparam int SMP_W  = 16;   // sample and result
    localparam int CNT_W  = 7;    // out_count register
    localparam int MODE_W = 2;    // interp_mode register
    localparam int CW     = 26;   // polynomial coefficients
    localparam int Y_W    = 28;   // cubic quotient before the divide by six

    // Divide by six as multiply by ceil(2^SIX_SH / 6), exact below 2^Y_W
    localparam int           SIX_SH    = Y_W + 3;
    localparam logic [Y_W:0] SIX_RECIP = 29'd357913942;

    localparam logic [CNT_W-1:0]  OCNT_RST  = 7'd64;
    localparam logic [MODE_W-1:0] MODE_QUAD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CUB  = 2'd2;

    // Register indexes on the config port
    typedef enum logic {REG_MODE, REG_COUNT} t_reg;

    typedef enum logic [1:0] {M_LIN, M_QUAD, M_CUB} t_mode;
    typedef enum logic [1:0] {P_H1, P_RND, P_H2} t_post;

    typedef enum logic [3:0] {
        S_LOAD, S_DIV, S_DWAIT, S_RD, S_COEF, S_MUL, S_MWAIT, S_D6, S_D6W, S_FIN
    } t_state;

    typedef struct packed {
        logic       store;
        logic       div_go;
        logic       step_set;
        logic       rd;
        logic [1:0] rd_k;
        logic       grab;
        logic [1:0] grab_k;
        logic       coef;
        logic       mul_go;
        logic       post;
        t_post      post_op;
        logic       six_go;
        logic       fin;
    } t_cmd;

    typedef struct packed {
        logic  div_done;
        logic  mul_done;
        logic  out_full;
        logic  last;
        t_mode mode;
    } t_stat;

endpackage

>>> rtl/core/prsm_div.sv
module prsm_div
    import prsm_pkg::*;
#(
    parameter int DW = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [DW-1:0]    i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DW-1:0]    o_quot
);
    localparam int CNTB = $clog2(DW + 1);

    logic [DW-1:0]    r_q;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_dv;
    logic [CNTB-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [CNT_W:0] rs;
    logic [CNT_W:0] diff;
    logic           ge;

    // One quotient bit per cycle, restoring
    assign rs   = {r_rem, r_q[DW-1]};
    assign diff = rs - {1'b0, r_dv};
    assign ge   = (rs >= {1'b0, r_dv});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTB'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTB'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dv  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[CNT_W-1:0] : rs[CNT_W-1:0];
            r_q   <= {r_q[DW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> rtl/core/prsm_mul.sv
module prsm_mul
    import prsm_pkg::*;
#(
    parameter int W  = 64,
    parameter int UW = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic signed [W-1:0] i_h,
    input  logic [UW-1:0]       i_u,
    output logic                o_done,
    output logic signed [W-1:0] o_p
);
    localparam int CNTB = $clog2(UW + 1);

    logic signed [W-1:0] r_acc;
    logic signed [W-1:0] r_mc;
    logic [UW-1:0]       r_mp;
    logic [CNTB-1:0]     r_cnt;
    logic                r_busy;
    logic                r_done;

    // Shift-add, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTB'(UW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTB'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_acc <= '0;
            r_mc  <= i_h;
            r_mp  <= i_u;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= r_mc <<< 1;
            r_mp <= r_mp >> 1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

>>> rtl/core/prsm_dp.sv
module prsm_dp
    import prsm_pkg::*;
#(
    parameter int SRC_DEPTH = SRC_DEPTH_DEF,
    parameter int OUT_MAX   = OUT_MAX_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_addr,
    input  logic [CNT_W-1:0]        i_cfg_wdata,
    input  logic signed [SMP_W-1:0] i_sample,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic signed [SMP_W-1:0] o_out_value,
    output logic                    o_out_last
);
    localparam int LC_W  = $clog2(SRC_DEPTH + 1);
    localparam int AW    = $clog2(SRC_DEPTH);
    localparam int IDX_W = ACC_W - FRAC_BITS;
    localparam int IW    = ((IDX_W > LC_W) ? IDX_W : LC_W) + 2;
    localparam int UW    = FRAC_BITS + 1;
    localparam int W     = 2 * FRAC_BITS + 32;
    localparam int DIV_W = ((LC_W + FRAC_BITS) > ACC_W) ? (LC_W + FRAC_BITS) : ACC_W;
    localparam int Q6_W  = 2 * Y_W + 1 - SIX_SH;

    localparam logic signed [W-1:0] ONE_W   = W'(1) <<< FRAC_BITS;
    localparam logic signed [W-1:0] HALF_W  = W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [W-1:0] THREE_W = ONE_W + (ONE_W <<< 1);
    localparam logic signed [W-1:0] SAT_HI  = W'(32767);
    localparam logic signed [W-1:0] SAT_LO  = -W'(32768);

    // Config and run state
    logic [MODE_W-1:0] r_mode;
    logic [CNT_W-1:0]  r_ocnt;
    logic [LC_W-1:0]   r_lc;
    logic [LC_W-1:0]   r_n;
    logic [CNT_W-1:0]  r_cnt;
    logic [ACC_W-1:0]  r_step;
    logic [ACC_W-1:0]  r_phase;
    logic [CNT_W-1:0]  r_k;

    // Sample memory and point registers
    logic signed [SMP_W-1:0] mem [SRC_DEPTH];
    logic signed [SMP_W-1:0] r_rd;
    logic signed [SMP_W-1:0] r_p [4];

    // Arithmetic registers
    logic [UW-1:0]        r_u;
    logic signed [W-1:0]  r_h;
    logic signed [CW-1:0] r_b;
    logic signed [CW-1:0] r_c;
    logic                 r_yneg;
    logic [Y_W-1:0]       r_ymag;
    logic [2*Y_W:0]       r_yprod;

    // Output register
    logic                    r_ofull;
    logic signed [SMP_W-1:0] r_ov;
    logic                    r_ol;

    t_mode mode;
    always_comb begin
        if (r_mode == MODE_CUB) begin
            mode = M_CUB;
        end else if (r_mode == MODE_QUAD) begin
            mode = M_QUAD;
        end else begin
            mode = M_LIN;
        end
    end

    // Effective count: zero acts as one, clipped to OUT_MAX
    logic [CNT_W-1:0] cnt_eff;
    always_comb begin
        if (r_ocnt == '0) begin
            cnt_eff = CNT_W'(1);
        end else if (r_ocnt > CNT_W'(OUT_MAX)) begin
            cnt_eff = CNT_W'(OUT_MAX);
        end else begin
            cnt_eff = r_ocnt;
        end
    end

    logic            lc_full;
    logic [LC_W-1:0] lc_next;
    logic            last;
    assign lc_full = (r_lc == LC_W'(SRC_DEPTH));
    assign lc_next = lc_full ? r_lc : r_lc + 1'b1;
    assign last    = (r_k == r_cnt - 1'b1);

    // Point address: base by mode, then offset and clamp to [0, n-1]
    logic signed [IW-1:0] idx;
    logic signed [IW-1:0] n_s;
    logic signed [IW-1:0] base;
    logic signed [IW-1:0] pt;
    logic signed [IW-1:0] pt_c;
    logic [FRAC_BITS-1:0] t;
    logic [AW-1:0]        addr;

    assign t   = r_phase[FRAC_BITS-1:0];
    assign idx = $signed({{(IW-IDX_W){1'b0}}, r_phase[ACC_W-1:FRAC_BITS]});
    assign n_s = $signed({{(IW-LC_W){1'b0}}, r_n});

    always_comb begin
        case (mode)
            M_QUAD:  base = t[FRAC_BITS-1] ? idx : idx - IW'(1);
            M_CUB:   base = idx - IW'(1);
            default: base = (idx >= n_s - IW'(1)) ? n_s - IW'(2) : idx;
        endcase
        pt = base + $signed({{(IW-2){1'b0}}, i_cmd.rd_k});
        if (pt < 0) begin
            pt_c = '0;
        end else if (pt > n_s - IW'(1)) begin
            pt_c = n_s - IW'(1);
        end else begin
            pt_c = pt;
        end
    end
    assign addr = pt_c[AW-1:0];

    // Sample memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !lc_full) begin
            mem[r_lc[AW-1:0]] <= i_sample;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[addr];
        end
    end

    // Coefficients from the four points
    logic signed [CW-1:0] p0, p1, p2, p3, d1, d2, d3, e2;
    logic signed [CW-1:0] a2, b2, a6, b6, c6;
    always_comb begin
        p0 = CW'(r_p[0]);
        p1 = CW'(r_p[1]);
        p2 = CW'(r_p[2]);
        p3 = CW'(r_p[3]);
        d1 = p1 - p0;
        d2 = p2 - p0;
        d3 = p3 - p0;
        a2 = d2 - (d1 <<< 1);
        b2 = (d1 <<< 1) - a2;
        a6 = d3 - (d2 + (d2 <<< 1)) + (d1 + (d1 <<< 1));
        e2 = d2 - (d1 <<< 1);
        b6 = (e2 + (e2 <<< 1)) - (a6 + (a6 <<< 1));
        c6 = (d1 <<< 2) + (d1 <<< 1) - a6 - b6;
    end

    // Shared multiplier
    logic                mul_done;
    logic signed [W-1:0] mul_p;
    prsm_mul #(.W(W), .UW(UW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_h     (r_h),
        .i_u     (r_u),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    logic signed [W-1:0] rnd;
    logic signed [W-1:0] b_sh;
    logic signed [W-1:0] c_sh;
    assign rnd  = (mul_p + HALF_W) >>> FRAC_BITS;
    assign b_sh = $signed({{(W-CW){r_b[CW-1]}}, r_b}) <<< FRAC_BITS;
    assign c_sh = $signed({{(W-CW){r_c[CW-1]}}, r_c}) <<< FRAC_BITS;

    // Step rate divider
    logic [DIV_W-1:0] dvd;
    logic             div_done;
    logic [DIV_W-1:0] quot;

    assign dvd = DIV_W'({r_n, {FRAC_BITS{1'b0}}});

    prsm_div #(.DW(DIV_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (dvd),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Cubic divide by six on the magnitude; negative values take |y| + 5
    // so that the quotient rounds toward minus infinity
    logic signed [W-1:0] y_full;
    logic signed [W-1:0] y_abs;
    logic [Y_W-1:0]      y_mag;
    assign y_full = (r_h + THREE_W) >>> FRAC_BITS;
    assign y_abs  = y_full[W-1] ? -y_full : y_full;
    assign y_mag  = y_full[W-1] ? Y_W'(y_abs + W'(5)) : Y_W'(y_abs);

    // Final value by mode, then saturation
    logic signed [W-1:0]     p0w, qw, q6, v;
    logic signed [SMP_W-1:0] v_sat;
    always_comb begin
        p0w = W'(r_p[0]);
        qw  = $signed({{(W-Q6_W){1'b0}}, r_yprod[2*Y_W:SIX_SH]});
        q6  = r_yneg ? -qw : qw;
        case (mode)
            M_QUAD:  v = p0w + ((r_h + ONE_W) >>> (FRAC_BITS + 1));
            M_CUB:   v = p0w + q6;
            default: v = p0w + r_h;
        endcase
        if (v > SAT_HI) begin
            v_sat = SMP_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            v_sat = SMP_W'(SAT_LO);
        end else begin
            v_sat = v[SMP_W-1:0];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_ocnt  <= OCNT_RST;
            r_lc    <= '0;
            r_n     <= '0;
            r_cnt   <= CNT_W'(1);
            r_step  <= '0;
            r_phase <= '0;
            r_k     <= '0;
            r_ofull <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_addr))
                    REG_MODE:  r_mode <= i_cfg_wdata[MODE_W-1:0];
                    default:   r_ocnt <= i_cfg_wdata;
                endcase
            end
            if (i_cmd.store) begin
                r_lc  <= lc_next;
                r_n   <= lc_next;
                r_cnt <= cnt_eff;
            end
            if (i_cmd.step_set) begin
                r_step  <= quot[ACC_W-1:0];
                r_phase <= '0;
                r_k     <= '0;
            end
            if (i_cmd.fin) begin
                r_ofull <= 1'b1;
                r_phase <= r_phase + r_step;
                r_k     <= r_k + 1'b1;
                if (last) begin
                    r_lc <= '0;
                end
            end else if (r_ofull && i_out_ready) begin
                r_ofull <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.grab) begin
            r_p[i_cmd.grab_k] <= r_rd;
        end
        if (i_cmd.coef) begin
            r_u <= (mode == M_LIN || (mode == M_QUAD && t[FRAC_BITS-1]))
                   ? {1'b0, t} : {1'b1, t};
            case (mode)
                M_QUAD: begin
                    r_h <= W'(a2);
                    r_b <= b2;
                end
                M_CUB: begin
                    r_h <= W'(a6);
                    r_b <= b6;
                    r_c <= c6;
                end
                default: r_h <= W'(d1);
            endcase
        end
        if (i_cmd.post) begin
            case (i_cmd.post_op)
                P_H1:    r_h <= mul_p + b_sh;
                P_H2:    r_h <= rnd + c_sh;
                default: r_h <= rnd;
            endcase
        end
        if (i_cmd.six_go) begin
            r_ymag <= y_mag;
            r_yneg <= y_full[W-1];
        end
        r_yprod <= r_ymag * SIX_RECIP;
        if (i_cmd.fin) begin
            r_ov <= v_sat;
            r_ol <= last;
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.mul_done = mul_done;
    assign o_stat.out_full = r_ofull;
    assign o_stat.last     = last;
    assign o_stat.mode     = mode;

    assign o_out_valid = r_ofull;
    assign o_out_value = r_ov;
    assign o_out_last  = r_ol;

endmodule

>>> rtl/core/prsm_ctrl.sv
module prsm_ctrl
    import prsm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state     r_state, n_state;
    logic [2:0] r_rk, n_rk;
    logic [1:0] r_pass, n_pass;
    logic       final_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_rk    <= '0;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_rk    <= n_rk;
            r_pass  <= n_pass;
        end
    end

    // Last multiply pass of the current mode
    assign final_pass = (i_stat.mode == M_LIN) ||
                        (i_stat.mode == M_QUAD && r_pass == 2'd1) ||
                        (r_pass == 2'd2);

    always_comb begin
        n_state    = r_state;
        n_rk       = r_rk;
        n_pass     = r_pass;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_in_last) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.step_set = 1'b1;
                    n_rk           = '0;
                    n_state        = S_RD;
                end
            end
            // Four reads, each read's data grabbed in the cycle after it
            S_RD: begin
                if (r_rk != 3'd4) begin
                    o_cmd.rd   = 1'b1;
                    o_cmd.rd_k = r_rk[1:0];
                end
                if (r_rk != 3'd0) begin
                    o_cmd.grab   = 1'b1;
                    o_cmd.grab_k = 2'(r_rk - 3'd1);
                end
                n_rk = r_rk + 3'd1;
                if (r_rk == 3'd4) begin
                    n_state = S_COEF;
                end
            end
            S_COEF: begin
                o_cmd.coef = 1'b1;
                n_pass     = '0;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_go = 1'b1;
                n_state      = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.post = 1'b1;
                    if (final_pass) begin
                        o_cmd.post_op = P_RND;
                        n_state = (i_stat.mode == M_CUB) ? S_D6 : S_FIN;
                    end else begin
                        o_cmd.post_op = (r_pass == 2'd0) ? P_H1 : P_H2;
                        n_pass  = r_pass + 2'd1;
                        n_state = S_MUL;
                    end
                end
            end
            // Capture the value to divide, then wait in S_D6W while the product is registered
            S_D6: begin
                o_cmd.six_go = 1'b1;
                n_state      = S_D6W;
            end
            S_D6W: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.out_full) begin
                    o_cmd.fin = 1'b1;
                    n_rk      = '0;
                    n_state   = i_stat.last ? S_LOAD : S_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

endmodule

>>> rtl/core/polynomial_resampler.sv
// Loading: one source sample per cycle, ready held high between runs.
// After the last sample: the step comes from a restoring divide, DIV_W = max(LC_W+FRAC_BITS, 25).
// Each result then takes P multiply passes on the shared shift-add multiplier
// (1 linear, 2 quadratic, 3 cubic); cubic then adds the divide by six.
// Output register lets the next run load while the last result waits.
// Reset (synchronous, active low): mode linear, out_count 64, counters and phase cleared.
module polynomial_resampler
    import prsm_pkg::*;
#(
    parameter int SRC_DEPTH = SRC_DEPTH_DEF,
    parameter int OUT_MAX   = OUT_MAX_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // [15:0] in_sample
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] out_value
    output logic             m_axis_tlast
);
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;
    logic signed [SMP_W-1:0] out_value;

    prsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    prsm_dp #(
        .SRC_DEPTH (SRC_DEPTH),
        .OUT_MAX   (OUT_MAX),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    ($signed(s_axis_tdata)),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_value (out_value),
        .o_out_last  (m_axis_tlast)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tdata  = out_value;

endmodule
